// ===== sv/http_content_length_framer_unit_defines.svh =====
// Assertion macros for the content-length framer.
// Included by the top level; needs nothing else.
`ifndef HTTP_CONTENT_LENGTH_FRAMER_UNIT_DEFINES_SVH
`define HTTP_CONTENT_LENGTH_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CLF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/clf_pkg.sv =====
// Shared types, constants and character lookups for the content-length framer.
// No dependencies.
`timescale 1ns / 1ps

package clf_pkg;

    // Field widths and default length width
    localparam int unsigned LENGTH_BITS_DEF = 32;
    localparam int unsigned OUT_W           = 32;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned NAME_LEN        = 14;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;

    // One result per byte
    typedef struct packed {
        logic             header_done;
        logic             message_done;
        logic [OUT_W-1:0] length_value;
        logic [OUT_W-1:0] body_count;
        logic             length_missing;
        logic             length_overflow;
    } t_result;

    // Characters of the header field name, by match position
    function automatic logic [BYTE_W-1:0] name_char(input logic [3:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of the header terminator CR LF CR LF
    function automatic logic [BYTE_W-1:0] term_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            2'd0:    c = CH_CR;
            2'd1:    c = CH_LF;
            2'd2:    c = CH_CR;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/clf_if.sv =====
// Stream interfaces for the content-length framer: byte in, result out.
// Depends on clf_pkg.
`timescale 1ns / 1ps

interface clf_byte_if;
    import clf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface clf_result_if;
    import clf_pkg::*;
    logic             valid;
    logic             ready;
    logic             header_done;
    logic             message_done;
    logic [OUT_W-1:0] length_value;
    logic [OUT_W-1:0] body_count;
    logic             length_missing;
    logic             length_overflow;

    modport source (output valid, output header_done, output message_done,
                    output length_value, output body_count, output length_missing,
                    output length_overflow, input ready);
    modport sink   (input valid, input header_done, input message_done,
                    input length_value, input body_count, input length_missing,
                    input length_overflow, output ready);
endinterface

// ===== sv/http_content_length_framer_unit.sv =====
// Content-length framer for a response byte stream: one result per byte.
//
// Channels: i_rx carries one response byte per transfer (valid/ready);
// o_res returns one result per byte: header_done, message_done, the parsed
// length (saturated, flagged by length_overflow), the body count and
// length_missing on the terminator byte when no length field was seen.
// A byte transferred on i_rx passes the input register and then the result
// register, from which its result is shown on o_res.
// Throughput: one byte per cycle while o_res is not stalled, set by the single
// framing core stage; the decimal step is one shift-add per byte.
// A stalled o_res holds its result; the core and input register then hold
// too, and i_rx.ready drops once the input register is full.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// framer to searching for the length field. After each completed message
// the framer clears itself in the same step.
// Depends on clf_pkg, the channel interfaces and the stage modules.
`timescale 1ns / 1ps
`include "http_content_length_framer_unit_defines.svh"

module http_content_length_framer_unit #(
    parameter int unsigned LENGTH_BITS = clf_pkg::LENGTH_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    clf_byte_if.sink     i_rx,
    clf_result_if.source o_res
);
    import clf_pkg::*;

    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_byte;
    logic              w_out_free;
    logic              w_fire;
    t_result           w_result;

    // Move a byte through the core when the result register can take it
    assign w_fire = w_in_valid && w_out_free;

    clf_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    clf_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (w_in_byte),
        .o_result (w_result)
    );

    clf_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_res    (o_res)
    );

    // A completed message always carries header_done
    `CLF_ASSERT_NOW(a_done_has_header, i_clk, i_rst_n, o_res.valid && o_res.message_done, o_res.header_done, "message_done without header_done")

    // A missing length field completes the message at once with zero length
    `CLF_ASSERT_NOW(a_missing_is_zero, i_clk, i_rst_n, o_res.valid && o_res.length_missing, o_res.message_done && (o_res.length_value == '0), "length_missing without zero-length completion")

    // A byte passed through the core shows up as a result next cycle
    `CLF_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, o_res.valid, "core transfer produced no result")

endmodule

// ===== sv/clf_in_stage.sv =====
// Input register of the content-length framer: holds one byte for the core.
// Depends on clf_pkg and clf_byte_if.
`timescale 1ns / 1ps

module clf_in_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    clf_byte_if.sink                  i_rx,
    input  logic                      i_take,
    output logic                      o_valid,
    output logic [clf_pkg::BYTE_W-1:0] o_byte
);
    import clf_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_load;

    // Refill whenever the held byte is empty or leaves this cycle
    assign i_rx.ready = !r_valid || i_take;
    assign w_load     = i_rx.valid && i_rx.ready;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the byte on each transfer
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== sv/clf_core.sv =====
// Framing core: header scan, length parse, terminator match and body count.
// Depends on clf_pkg.
`timescale 1ns / 1ps

module clf_core #(
    parameter int unsigned LENGTH_BITS = clf_pkg::LENGTH_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [clf_pkg::BYTE_W-1:0] i_byte,
    output clf_pkg::t_result           o_result
);
    import clf_pkg::*;

    localparam int unsigned WIDE_W = LENGTH_BITS + 4;
    localparam int unsigned EXT_W  = (LENGTH_BITS > OUT_W) ? LENGTH_BITS : OUT_W;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SKIP,
        PH_VALUE,
        PH_CLOSED
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_term, n_term;
    logic [3:0]             r_name, n_name;
    logic [LENGTH_BITS-1:0] r_acc, n_acc;
    logic [LENGTH_BITS-1:0] r_body, n_body;
    logic                   r_in_body, n_in_body;
    logic                   r_sat, n_sat;

    logic              w_is_digit;
    logic              w_is_blank;
    logic [BYTE_W-1:0] w_off;
    logic [WIDE_W-1:0] w_wide;
    logic              w_ovf;
    logic              w_hd;
    logic              w_md;
    logic              w_miss;
    logic [EXT_W-1:0]  w_acc_ext;
    logic [EXT_W-1:0]  w_body_ext;

    // Decimal step: acc * 10 + digit, done as two shifts and an add
    assign w_is_digit = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign w_is_blank = (i_byte == CH_SPACE) || (i_byte == CH_TAB);
    assign w_off      = i_byte - CH_0;
    assign w_wide     = ({4'b0000, r_acc} << 3) + ({4'b0000, r_acc} << 1)
                        + WIDE_W'(w_off[3:0]);
    assign w_ovf      = |w_wide[WIDE_W-1:LENGTH_BITS];

    // Next state and result for the byte in hand
    always_comb begin
        n_phase   = r_phase;
        n_term    = r_term;
        n_name    = r_name;
        n_acc     = r_acc;
        n_body    = r_body;
        n_in_body = r_in_body;
        n_sat     = r_sat;
        w_hd      = 1'b0;
        w_md      = 1'b0;
        w_miss    = 1'b0;

        if (r_in_body) begin
            // Count body bytes; nothing is parsed here
            n_body = r_body + LENGTH_BITS'(1);
            w_hd   = 1'b1;
            w_md   = (n_body == r_acc);
        end else begin
            // Length field parser
            unique case (r_phase)
                PH_SEARCH: begin
                    if ((r_name < 4'(NAME_LEN)) && (i_byte == name_char(r_name))) begin
                        if (r_name == 4'(NAME_LEN - 1)) begin
                            n_phase = PH_SKIP;
                            n_name  = '0;
                        end else begin
                            n_name = r_name + 4'd1;
                        end
                    end else begin
                        n_name = (i_byte == CH_C) ? 4'd1 : 4'd0;
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_VALUE;
                    n_name  = '0;
                end
                PH_VALUE: begin
                    if (w_is_digit) begin
                        if (r_sat || w_ovf) begin
                            n_acc = '1;
                            n_sat = 1'b1;
                        end else begin
                            n_acc = w_wide[LENGTH_BITS-1:0];
                        end
                        n_name = 4'd1;
                    end else if (!(w_is_blank && (r_name == 4'd0))) begin
                        n_phase = PH_CLOSED;
                    end
                end
                PH_CLOSED: begin
                end
                default: begin
                end
            endcase

            // Terminator match
            if (i_byte == term_char(r_term)) begin
                if (r_term == 2'd3) begin
                    n_term = '0;
                    w_hd   = 1'b1;
                    w_miss = (n_phase == PH_SEARCH);
                    n_body = '0;
                    if (n_acc == '0) begin
                        w_md = 1'b1;
                    end else begin
                        n_in_body = 1'b1;
                    end
                end else begin
                    n_term = r_term + 2'd1;
                end
            end else begin
                n_term = (i_byte == CH_CR) ? 2'd1 : 2'd0;
            end
        end

        // Result shows values held before the clear
        w_acc_ext  = EXT_W'(n_acc);
        w_body_ext = EXT_W'(n_body);
        o_result.header_done     = w_hd;
        o_result.message_done    = w_md;
        o_result.length_value    = w_acc_ext[OUT_W-1:0];
        o_result.body_count      = w_body_ext[OUT_W-1:0];
        o_result.length_missing  = w_miss;
        o_result.length_overflow = n_sat;

        // Clear for the next response once the message completes
        if (w_md) begin
            n_phase   = PH_SEARCH;
            n_term    = '0;
            n_name    = '0;
            n_acc     = '0;
            n_body    = '0;
            n_in_body = 1'b0;
            n_sat     = 1'b0;
        end
    end

    // Hold framing state; advance on each byte taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_term    <= '0;
            r_name    <= '0;
            r_acc     <= '0;
            r_body    <= '0;
            r_in_body <= 1'b0;
            r_sat     <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_term    <= n_term;
            r_name    <= n_name;
            r_acc     <= n_acc;
            r_body    <= n_body;
            r_in_body <= n_in_body;
            r_sat     <= n_sat;
        end
    end

endmodule

// ===== sv/clf_out_stage.sv =====
// Result register of the content-length framer, drives the result channel.
// Depends on clf_pkg and clf_result_if.
`timescale 1ns / 1ps

module clf_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  clf_pkg::t_result i_result,
    output logic             o_free,
    clf_result_if.source     o_res
);
    import clf_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held result leaves this cycle
    assign o_free = !r_valid || o_res.ready;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.header_done     = r_result.header_done;
    assign o_res.message_done    = r_result.message_done;
    assign o_res.length_value    = r_result.length_value;
    assign o_res.body_count      = r_result.body_count;
    assign o_res.length_missing  = r_result.length_missing;
    assign o_res.length_overflow = r_result.length_overflow;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for the content-length framer: byte stream in, one result per byte.
// Depends on clf_pkg, the clf_byte_if/clf_result_if interfaces and the framer top level.
`timescale 1ns / 1ps

module tb;
    import clf_pkg::*;

    localparam int unsigned          SETTLE_CYCLES = 12;
    localparam int unsigned          HOLD_CYCLES   = 150;
    localparam int unsigned          HOLD_EVERY    = 300;
    localparam int unsigned          STREAM_BYTES  = 720;
    localparam int unsigned          MAX_PRINTS    = 40;
    localparam logic [8*NAME_LEN-1:0] FIELD_NAME   = "Content-Length";
    localparam logic [OUT_W-1:0]     LENGTH_MAX    = '1;
    localparam logic [BYTE_W-1:0]    CH_COLON      = 8'h3A;

    typedef enum logic [1:0] {
        PH_SEEK_NAME, PH_SKIP_SEP, PH_DIGITS, PH_CLOSED
    } t_len_phase;

    typedef enum logic [1:0] {
        RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY
    } t_rdy_mode;

    typedef struct {
        logic [BYTE_W-1:0] value;
        bit                drain;
    } t_stream_byte;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    clf_byte_if   rx_if ();
    clf_result_if res_if ();

    http_content_length_framer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always #2 i_clk = ~i_clk;

    // Framer state as the bench sees it
    logic [2:0]       term_seen = '0;
    logic [3:0]       name_seen = '0;
    t_len_phase       len_phase = PH_SEEK_NAME;
    logic [OUT_W-1:0] len_acc   = '0;
    logic [OUT_W-1:0] body_cnt  = '0;
    logic             in_body   = 1'b0;
    logic             len_sat   = 1'b0;

    t_stream_byte stream_q[$];
    t_result      frame_results_q[$];

    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    bit          rx_took      = 1'b0;
    int unsigned gap_left     = 0;
    int unsigned burst_left   = 0;
    int unsigned hold_left    = 0;
    int unsigned mode_left    = 0;
    int unsigned next_hold_at = HOLD_EVERY;
    t_rdy_mode   rdy_mode     = RDY_ALWAYS;

    // Advance the framer by one byte and return the result it shows
    function automatic t_result frame_byte(input logic [BYTE_W-1:0] b);
        t_result     r;
        logic [63:0] grown;
        r = '0;
        if (in_body) begin
            body_cnt        = body_cnt + 1'b1;
            r.header_done   = 1'b1;
            r.message_done  = (body_cnt == len_acc);
        end else begin
            // Length field parser; terminator bytes feed it too
            case (len_phase)
                PH_SEEK_NAME: begin
                    if (b == FIELD_NAME[8*(NAME_LEN-1-name_seen) +: 8]) begin
                        name_seen = name_seen + 1'b1;
                        if (name_seen == NAME_LEN) begin
                            len_phase = PH_SKIP_SEP;
                            name_seen = '0;
                        end
                    end else begin
                        name_seen = (b == CH_C) ? 4'd1 : 4'd0;
                    end
                end
                PH_SKIP_SEP: begin
                    len_phase = PH_DIGITS;
                    name_seen = '0;
                end
                PH_DIGITS: begin
                    if (b >= CH_0 && b <= CH_9) begin
                        grown = 64'(len_acc) * 64'd10 + 64'(b - CH_0);
                        if (len_sat || grown > 64'(LENGTH_MAX)) begin
                            len_acc = LENGTH_MAX;
                            len_sat = 1'b1;
                        end else begin
                            len_acc = grown[OUT_W-1:0];
                        end
                        name_seen = 4'd1;
                    end else if (!((b == CH_SPACE || b == CH_TAB) && name_seen == 0)) begin
                        len_phase = PH_CLOSED;
                    end
                end
                default: ;
            endcase
            // CR LF CR LF match; a stray CR restarts it
            if (b == (term_seen[0] ? CH_LF : CH_CR)) begin
                term_seen = term_seen + 1'b1;
            end else begin
                term_seen = (b == CH_CR) ? 3'd1 : 3'd0;
            end
            if (term_seen == 3'd4) begin
                term_seen        = '0;
                r.header_done    = 1'b1;
                r.length_missing = (len_phase == PH_SEEK_NAME);
                body_cnt         = '0;
                if (len_acc == 0) begin
                    r.message_done = 1'b1;
                end else begin
                    in_body = 1'b1;
                end
            end
        end
        r.length_value    = len_acc;
        r.body_count      = body_cnt;
        r.length_overflow = len_sat;
        // Clear everything once the message completes
        if (r.message_done) begin
            term_seen = '0;
            name_seen = '0;
            len_phase = PH_SEEK_NAME;
            len_acc   = '0;
            body_cnt  = '0;
            in_body   = 1'b0;
            len_sat   = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        // Keep the log short on a badly broken build; every mismatch still counts
        if (mismatches < MAX_PRINTS)
            $display("%0t: result %0d: %s got %0h, expected %0h",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        t_stream_byte sb;
        sb.value = b;
        sb.drain = 1'b0;
        stream_q.push_back(sb);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_crlf();
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic push_letters(input int unsigned n);
        repeat (n) push_byte(8'($urandom_range(8'h61, 8'h7A)));
    endtask

    // Queue one response: header lines, terminator and a body of the announced size (five bytes if saturating)
    task automatic build_message(input bit saturate, input bit drain_first);
        int unsigned first;
        int unsigned body_len;
        int unsigned val;
        bit          has_name;
        first    = stream_q.size();
        body_len = 0;
        has_name = saturate || ($urandom_range(0, 7) != 0);
        // Leading lines: partial names and stray CRs
        repeat ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 2))
                0: push_text("Content-Type: text");
                1: begin
                    push_text("Cont");
                    push_letters($urandom_range(1, 4));
                end
                default: begin
                    push_letters($urandom_range(1, 3));
                    push_byte(CH_CR);
                    push_letters(1);
                end
            endcase
            push_crlf();
        end
        if (has_name) begin
            push_text("Content-Length");
            push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : CH_COLON);
            repeat ($urandom_range(0, 3)) push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            if (saturate) begin
                push_byte(8'(CH_0 + $urandom_range(1, 9)));
                repeat ($urandom_range(10, 19)) push_byte(8'(CH_0 + $urandom_range(0, 9)));
                body_len = 5;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        // A non-digit closes the value at zero
                        push_letters(1);
                        push_text("12");
                    end
                    1: push_byte(CH_0);
                    default: begin
                        val = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                          : $urandom_range(1, 12);
                        if ($urandom_range(0, 3) == 0)
                            push_text("00");
                        push_text($sformatf("%0d", val));
                        body_len = val;
                        case ($urandom_range(0, 3))
                            0: push_text(" 7");
                            1: push_text(";q");
                            default: ;
                        endcase
                    end
                endcase
            end
            push_crlf();
            // A second name is ignored
            if ($urandom_range(0, 3) == 0) begin
                push_text("Content-Length: 99");
                push_crlf();
            end
        end
        if (!has_name || $urandom_range(0, 1) != 0) begin
            push_text("Host: h");
            push_crlf();
        end
        push_crlf();
        // Body: may carry terminators and names that must not be searched
        if (body_len != 0 && $urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 4 && body_len != 0; i++) begin
                push_byte(i[0] ? CH_LF : CH_CR);
                body_len--;
            end
        end
        repeat (body_len) begin
            case ($urandom_range(0, 7))
                0: push_byte(CH_CR);
                1: push_byte(CH_LF);
                2: push_byte(CH_C);
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
        if (drain_first || $urandom_range(0, 7) == 0)
            stream_q[first].drain = 1'b1;
    endtask

    // Driver: offer bytes in bursts, hold each offer until its transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= '0;
        end else if (!rx_if.valid || rx_took) begin
            rx_took = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                rx_if.valid <= 1'b0;
            end else if (stream_q.size() == 0 ||
                         (stream_q[0].drain && frame_results_q.size() != 0)) begin
                rx_if.valid <= 1'b0;
            end else begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= stream_q[0].value;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = $urandom_range(3, 10);
                        1:       gap_left = $urandom_range(1, 2);
                        default: gap_left = 0;
                    endcase
                end
            end
        end
    end

    // Receiver: stall on its own pattern, with a long hold every few hundred results
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (hold_left == 0 && results_seen >= next_hold_at) begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + HOLD_EVERY;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rdy_mode  = t_rdy_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 150);
                end else begin
                    mode_left--;
                end
                case (rdy_mode)
                    RDY_ALWAYS: res_if.ready <= 1'b1;
                    RDY_MOSTLY: res_if.ready <= ($urandom_range(0, 3) != 0);
                    default:    res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor: check result transfers, then predict from byte transfers
    always @(posedge i_clk) begin : stream_monitor
        t_result want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (frame_results_q.size() == 0) begin
                    report_mismatch("result with none outstanding", '0, '0);
                end else begin
                    want = frame_results_q.pop_front();
                    if (res_if.header_done !== want.header_done)
                        report_mismatch("header_done", res_if.header_done, want.header_done);
                    if (res_if.message_done !== want.message_done)
                        report_mismatch("message_done", res_if.message_done, want.message_done);
                    if (res_if.length_value !== want.length_value)
                        report_mismatch("length_value", res_if.length_value, want.length_value);
                    if (res_if.body_count !== want.body_count)
                        report_mismatch("body_count", res_if.body_count, want.body_count);
                    if (res_if.length_missing !== want.length_missing)
                        report_mismatch("length_missing", res_if.length_missing,
                                        want.length_missing);
                    if (res_if.length_overflow !== want.length_overflow)
                        report_mismatch("length_overflow", res_if.length_overflow,
                                        want.length_overflow);
                end
            end
            if (rx_if.valid && rx_if.ready) begin
                frame_results_q.push_back(frame_byte(rx_if.rx_byte));
                void'(stream_q.pop_front());
                rx_took = 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int unsigned msg_count;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        msg_count     = 0;

        // Byte extremes, a stray CR before a bare terminator, then a short message
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_CR);
        push_crlf();
        push_crlf();
        push_text("Content-Length:");
        push_byte(CH_TAB);
        push_text(" 2");
        push_crlf();
        push_crlf();
        push_text("ab");

        while (stream_q.size() < STREAM_BYTES) begin
            build_message(1'b0, msg_count == 0);
            msg_count++;
        end
        // Saturating length last: its body never completes
        build_message(1'b1, 1'b0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (stream_q.size() != 0 || frame_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/clf_pkg.sv
sv/clf_if.sv
sv/clf_in_stage.sv
sv/clf_core.sv
sv/clf_out_stage.sv
sv/http_content_length_framer_unit.sv
tb/sv/tb.sv
